### hw/rtl/tprh_pkg.sv
// ----------------------------------------------------------------------------
// tprh_pkg
// Shared widths, register indexes, sequencer states and saturation helpers
// for the three-pole resonant highpass filter.
// ----------------------------------------------------------------------------
package tprh_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int STAGE_W     = 24;
	localparam int COEFF_W     = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int OPND_W      = 32;
	localparam int PROD_W      = 49;

	localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK = 2'd1;

	localparam logic [COEFF_W-1:0] CUTOFF_RESET   = 16'd65470;
	localparam logic [COEFF_W-1:0] FEEDBACK_RESET = 16'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FB_MUL,
		ST_S1_DIF,
		ST_S1_MUL,
		ST_S1_UPD,
		ST_S2_MUL,
		ST_S2_UPD,
		ST_S3_MUL,
		ST_S3_UPD,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic en;
		logic sel_fb;
	} mul_ctrl_t;

	function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
		if (v > 34'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -34'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -17'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

### hw/rtl/tprh_mul.sv
// ----------------------------------------------------------------------------
// tprh_mul
// Shared multiplier: unsigned 16-bit coefficient times signed 32-bit operand,
// product registered.
// ----------------------------------------------------------------------------
module tprh_mul (
	input  logic                                 clk,
	input  tprh_pkg::mul_ctrl_t                  ctrl,
	input  logic [tprh_pkg::COEFF_W-1:0]         cutoff,
	input  logic [tprh_pkg::COEFF_W-1:0]         feedback,
	input  logic signed [tprh_pkg::OPND_W-1:0]   opnd,
	output logic signed [tprh_pkg::PROD_W-1:0]   prod_q
);

	logic signed [tprh_pkg::COEFF_W:0]   coeff;
	logic signed [tprh_pkg::PROD_W-1:0]  prod;

	assign coeff = ctrl.sel_fb ? $signed({1'b0, feedback}) : $signed({1'b0, cutoff});
	assign prod  = coeff * opnd;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_q <= prod;
		end
	end

endmodule

### hw/rtl/three_pole_resonant_highpass.sv
// ----------------------------------------------------------------------------
// three_pole_resonant_highpass
// Three cascaded one-pole smoothing stages with resonance feedback into the
// first stage; output is input minus the third stage, saturated to 16 bits.
//
//   channel  signals                              direction
//   input    in_valid/in_ready, sample_in,        in
//            clear_stages
//   output   out_valid/out_ready, sample_out      out
//   config   cfg_we, cfg_index, cfg_data          in
//
// A request passes through the accept step, four products through the
// one shared multiplier each followed by its update step, and one output step.
// in_ready is high only while the sequencer is idle. A result waits in the
// output register; the next request is accepted while it waits. Reset clears
// the stages and loads the register reset values.
// ----------------------------------------------------------------------------
module three_pole_resonant_highpass (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [tprh_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic                                   clear_stages,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [tprh_pkg::SAMPLE_W-1:0]   sample_out,
	input  logic                                   cfg_we,
	input  logic [tprh_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [tprh_pkg::COEFF_W-1:0]           cfg_data
);

	tprh_pkg::seq_state_t state_q, state_d;
	tprh_pkg::mul_ctrl_t  mul_ctrl;

	logic [tprh_pkg::COEFF_W-1:0]         cutoff_q, feedback_q;
	logic signed [tprh_pkg::STAGE_W-1:0]  x_q, s1_q, s2_q, s3_q;
	logic signed [tprh_pkg::OPND_W-1:0]   diff_q, opnd;
	logic signed [tprh_pkg::PROD_W-1:0]   prod_q;
	logic signed [tprh_pkg::SAMPLE_W-1:0] out_q;
	logic                                 out_valid_q;

	logic signed [24:0] d12, d23, y25;
	logic signed [37:0] diff0;
	logic signed [23:0] stage_sel, stage_new;
	logic signed [33:0] upd_sum;
	logic               accept, load_out;

	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == tprh_pkg::ST_DONE) && (!out_valid_q || out_ready);

	assign d12   = $signed({s1_q[23], s1_q}) - $signed({s2_q[23], s2_q});
	assign d23   = $signed({s2_q[23], s2_q}) - $signed({s3_q[23], s3_q});
	assign diff0 = $signed({{14{x_q[23]}}, x_q}) - $signed({{14{s1_q[23]}}, s1_q})
	             + $signed({prod_q[48], prod_q[48:12]});
	assign y25   = $signed({x_q[23], x_q}) - $signed({s3_q[23], s3_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tprh_pkg::ST_IDLE:   if (in_valid) state_d = tprh_pkg::ST_FB_MUL;
			tprh_pkg::ST_FB_MUL: state_d = tprh_pkg::ST_S1_DIF;
			tprh_pkg::ST_S1_DIF: state_d = tprh_pkg::ST_S1_MUL;
			tprh_pkg::ST_S1_MUL: state_d = tprh_pkg::ST_S1_UPD;
			tprh_pkg::ST_S1_UPD: state_d = tprh_pkg::ST_S2_MUL;
			tprh_pkg::ST_S2_MUL: state_d = tprh_pkg::ST_S2_UPD;
			tprh_pkg::ST_S2_UPD: state_d = tprh_pkg::ST_S3_MUL;
			tprh_pkg::ST_S3_MUL: state_d = tprh_pkg::ST_S3_UPD;
			tprh_pkg::ST_S3_UPD: state_d = tprh_pkg::ST_DONE;
			tprh_pkg::ST_DONE:   if (load_out) state_d = tprh_pkg::ST_IDLE;
			default:             state_d = tprh_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready        = 1'b0;
		mul_ctrl.en     = 1'b0;
		mul_ctrl.sel_fb = 1'b0;
		opnd            = diff_q;
		stage_sel       = s1_q;
		case (state_q)
			tprh_pkg::ST_IDLE: in_ready = 1'b1;
			tprh_pkg::ST_FB_MUL: begin
				mul_ctrl.en     = 1'b1;
				mul_ctrl.sel_fb = 1'b1;
				opnd            = {{7{d12[24]}}, d12};
			end
			tprh_pkg::ST_S1_MUL: mul_ctrl.en = 1'b1;
			tprh_pkg::ST_S2_MUL: begin
				mul_ctrl.en = 1'b1;
				opnd        = {{7{d12[24]}}, d12};
			end
			tprh_pkg::ST_S2_UPD: stage_sel = s2_q;
			tprh_pkg::ST_S3_MUL: begin
				mul_ctrl.en = 1'b1;
				opnd        = {{7{d23[24]}}, d23};
			end
			tprh_pkg::ST_S3_UPD: stage_sel = s3_q;
			default: ;
		endcase
	end

	assign upd_sum   = $signed({{10{stage_sel[23]}}, stage_sel})
	                 + $signed({prod_q[48], prod_q[48:16]});
	assign stage_new = tprh_pkg::sat24(upd_sum);

	tprh_mul u_mul (
		.clk      (clk),
		.ctrl     (mul_ctrl),
		.cutoff   (cutoff_q),
		.feedback (feedback_q),
		.opnd     (opnd),
		.prod_q   (prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tprh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q   <= tprh_pkg::CUTOFF_RESET;
			feedback_q <= tprh_pkg::FEEDBACK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tprh_pkg::REG_CUTOFF:   cutoff_q   <= cfg_data;
				tprh_pkg::REG_FEEDBACK: feedback_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
			s2_q <= '0;
			s3_q <= '0;
		end else if (accept && clear_stages) begin
			s1_q <= '0;
			s2_q <= '0;
			s3_q <= '0;
		end else begin
			case (state_q)
				tprh_pkg::ST_S1_UPD: s1_q <= stage_new;
				tprh_pkg::ST_S2_UPD: s2_q <= stage_new;
				tprh_pkg::ST_S3_UPD: s3_q <= stage_new;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= {sample_in, 8'h00};
		end
		if (state_q == tprh_pkg::ST_S1_DIF) begin
			diff_q <= diff0[31:0];
		end
		if (load_out) begin
			out_q <= tprh_pkg::sat16(y25[24:8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == tprh_pkg::ST_FB_MUL)
		else $error("accepted request did not start the sequence");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && clear_stages |=> s1_q == '0 && s2_q == '0 && s3_q == '0)
		else $error("clear did not zero the stages");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && state_q == tprh_pkg::ST_IDLE)
		else $error("finished result not presented");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != tprh_pkg::ST_IDLE |-> !in_ready)
		else $error("ready while sequence in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("stalled result changed");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-pole resonant highpass filter. A
// fixed-point model of the three smoothing stages and the resonance feedback
// predicts every output sample from the accepted requests and the register
// settings. The bench starts with directed extremes and then runs random
// phases across several coefficient and feedback settings. Sender bursts,
// receiver stall patterns and one long receiver hold-off exercise the
// handshakes.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [tprh_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [tprh_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam longint STAGE_HI = 8388607;
	localparam longint STAGE_LO = -8388608;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	class highpass_tracker;
		longint cutoff, gain, s1, s2, s3;
		logic signed [tprh_pkg::SAMPLE_W-1:0] expected_out[$];
		int mismatches, requests, outputs, clears, out_clipped, stage_clipped;

		function new();
			cutoff = tprh_pkg::CUTOFF_RESET;
			gain = tprh_pkg::FEEDBACK_RESET;
			s1 = 0;
			s2 = 0;
			s3 = 0;
		endfunction

		function void write_reg(logic [tprh_pkg::CFG_INDEX_W-1:0] idx,
				logic [tprh_pkg::COEFF_W-1:0] data);
			case (idx)
				tprh_pkg::REG_CUTOFF: cutoff = data;
				tprh_pkg::REG_FEEDBACK: gain = data;
				default: ;
			endcase
		endfunction

		function longint smooth(longint stage, longint diff);
			longint v;
			v = stage + ((cutoff * diff) >>> 16);
			if (v > STAGE_HI) begin
				stage_clipped++;
				return STAGE_HI;
			end else if (v < STAGE_LO) begin
				stage_clipped++;
				return STAGE_LO;
			end
			return v;
		endfunction

		function void note_request(logic signed [tprh_pkg::SAMPLE_W-1:0] smp, logic clr);
			longint x, fb, y;
			x = longint'(smp) * 256;
			requests++;
			if (clr) begin
				clears++;
				s1 = 0;
				s2 = 0;
				s3 = 0;
			end
			fb = (gain * (s1 - s2)) >>> 12;
			s1 = smooth(s1, x - s1 + fb);
			s2 = smooth(s2, s1 - s2);
			s3 = smooth(s3, s2 - s3);
			y = (x - s3) >>> 8;
			if (y > 32767) begin
				y = 32767;
				out_clipped++;
			end else if (y < -32768) begin
				y = -32768;
				out_clipped++;
			end
			expected_out.push_back(y[tprh_pkg::SAMPLE_W-1:0]);
		endfunction

		function void check_output(logic signed [tprh_pkg::SAMPLE_W-1:0] act);
			logic signed [tprh_pkg::SAMPLE_W-1:0] want;
			if (expected_out.size() == 0) begin
				mismatches++;
				$error("sample_out with no request pending: actual %0d", act);
				return;
			end
			want = expected_out.pop_front();
			outputs++;
			if (act !== want) begin
				mismatches++;
				$error("sample_out mismatch: expected %0d, actual %0d", want, act);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [tprh_pkg::SAMPLE_W-1:0] sample_in = '0;
	logic clear_stages = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [tprh_pkg::SAMPLE_W-1:0] sample_out;
	logic cfg_we = 1'b0;
	logic [tprh_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [tprh_pkg::COEFF_W-1:0] cfg_data = '0;

	highpass_tracker track;
	int cycle_count = 0;
	int hold_request = 0;
	int hold_left = 0;
	int pat_pos = 0;
	int settings_used = 0;
	logic [15:0] stall_pat = '1;

	three_pole_resonant_highpass dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.clear_stages(clear_stages),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: long hold-off on request, otherwise a rotating stall pattern
	always @(posedge clk) begin
		if (hold_left == 0 && hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (pat_pos == 255) begin
			stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
				16'($urandom) | (16'd1 << $urandom_range(0, 15));
		end
		pat_pos = (pat_pos + 1) % 256;
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= stall_pat[pat_pos[3:0]];
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			track.check_output(sample_out);
	end

	task automatic send_request(input logic signed [tprh_pkg::SAMPLE_W-1:0] smp,
			input logic clr);
		in_valid <= 1'b1;
		sample_in <= smp;
		clear_stages <= clr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track.note_request(smp, clr);
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (track.expected_out.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [tprh_pkg::COEFF_W-1:0] cut,
			input logic [tprh_pkg::COEFF_W-1:0] fbg, input bit spare);
		logic [tprh_pkg::COEFF_W-1:0] junk;
		junk = 16'($urandom);
		settings_used++;
		cfg_we <= 1'b1;
		cfg_index <= tprh_pkg::REG_CUTOFF;
		cfg_data <= cut;
		@(posedge clk);
		track.write_reg(tprh_pkg::REG_CUTOFF, cut);
		cfg_index <= tprh_pkg::REG_FEEDBACK;
		cfg_data <= fbg;
		@(posedge clk);
		track.write_reg(tprh_pkg::REG_FEEDBACK, fbg);
		if (spare) begin
			cfg_index <= REG_SPARE_LO;
			cfg_data <= junk;
			@(posedge clk);
			track.write_reg(REG_SPARE_LO, junk);
			cfg_index <= REG_SPARE_HI;
			cfg_data <= ~junk;
			@(posedge clk);
			track.write_reg(REG_SPARE_HI, ~junk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [tprh_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return 16'($urandom_range(0, 512)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_phase(input int n, input bit squeeze);
		int burst_left;
		int gap;
		burst_left = 0;
		if (squeeze) begin
			hold_request = HOLD_OFF_CYCLES;
			burst_left = 40;
		end
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
				if (gap != 0)
					idle_gap(gap);
				burst_left = $urandom_range(1, 24);
			end
			send_request(pick_sample(), $urandom_range(0, 19) == 0);
			burst_left--;
		end
		wait_drained();
	endtask

	initial begin
		logic [tprh_pkg::COEFF_W-1:0] cut_list [8];
		logic [tprh_pkg::COEFF_W-1:0] gain_list [8];
		track = new();
		cut_list = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
			16'h0001};
		gain_list = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
			16'h0001};
		cut_list[4] = 16'($urandom);
		gain_list[4] = 16'($urandom);
		cut_list[5] = 16'($urandom);
		gain_list[5] = 16'($urandom_range(0, 8191));
		cut_list[6] = 16'($urandom_range(60000, 65535));
		gain_list[6] = 16'($urandom);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		send_request(16'sd0, 1'b0);
		send_request(16'sh7FFF, 1'b0);
		send_request(16'sh7FFF, 1'b0);
		send_request(16'sh8000, 1'b0);
		send_request(16'sh8000, 1'b0);
		send_request(16'sd1, 1'b0);
		send_request(-16'sd1, 1'b0);
		send_request(16'sh5555, 1'b0);
		send_request(16'shAAAA, 1'b1);
		send_request(16'sd0, 1'b1);
		wait_drained();

		// full cutoff: stages track the input, output clips on a full swing
		apply_setting(16'hFFFF, 16'h0000, 1'b1);
		repeat (4) send_request(16'sh7FFF, 1'b0);
		repeat (3) send_request(16'sh8000, 1'b0);
		send_request(16'sh7FFF, 1'b0);
		wait_drained();

		// full feedback drives the first stage into saturation
		apply_setting(16'hFFFF, 16'hFFFF, 1'b0);
		send_request(16'sh7FFF, 1'b1);
		send_request(16'sh7FFF, 1'b0);
		send_request(16'sh8000, 1'b0);
		send_request(16'sh7FFF, 1'b0);
		send_request(16'sh8000, 1'b0);
		send_request(16'sh8000, 1'b0);
		send_request(16'sh7FFF, 1'b0);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			apply_setting(cut_list[p], gain_list[p], p == 7);
			run_phase(115, p == 4);
		end

		if (track.expected_out.size() != 0) begin
			track.mismatches++;
			$error("%0d expected outputs never arrived", track.expected_out.size());
		end
		$display("Covered %0d samples over %0d register settings, %0d with a stage clear.",
			track.requests, settings_used, track.clears);
		$display("Checked %0d outputs; %0d clipped at the output, %0d stage updates saturated.",
			track.outputs, track.out_clipped, track.stage_clipped);
		if (track.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
